// ===== hdl/dbors_pkg.sv =====
// ============================================================================
// dbors_pkg: shared types and constants of the DRAM bank open-row scheduler
// Payload structs, status and command codes, register indexes and reset
// values, and the state types of the front and back sections.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

package dbors_pkg;

  // Field widths
  localparam int ADDR_W     = 64;
  localparam int SIZE_W     = 16;
  localparam int LAT_W      = 32;
  localparam int QCNT_W     = 4;
  localparam int STATUS_W   = 3;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 13;
  localparam int TIME_W     = 10;
  localparam int BW_W       = 11;
  localparam int CB_W       = 13;
  localparam int SHIFT_W    = 6;

  // Divider: two quotient bits per cycle over the size field
  localparam int DIV_STEPS = SIZE_W / 2;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS);
  localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(DIV_STEPS - 1);
  localparam int PROD_W = SIZE_W + TIME_W;

  // Commands
  localparam logic CMD_REQUEST = 1'b0;
  localparam logic CMD_FINISH  = 1'b1;

  // Result status codes
  localparam logic [STATUS_W-1:0] STS_REJECTED = 3'd0;
  localparam logic [STATUS_W-1:0] STS_STARTED  = 3'd1;
  localparam logic [STATUS_W-1:0] STS_QUEUED   = 3'd2;
  localparam logic [STATUS_W-1:0] STS_FIN_IDLE = 3'd3;
  localparam logic [STATUS_W-1:0] STS_FIN_NEXT = 3'd4;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_PRECHARGE  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ACTIVATE   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CAS        = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_COLUMN_GAP = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_BYTES_NS   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_COL_BYTES  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_ROW_SHIFT  = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_OVERHEAD   = 3'd7;

  // Register reset values
  localparam logic [TIME_W-1:0]  RST_PRECHARGE  = 10'd14;
  localparam logic [TIME_W-1:0]  RST_ACTIVATE   = 10'd14;
  localparam logic [TIME_W-1:0]  RST_CAS        = 10'd14;
  localparam logic [TIME_W-1:0]  RST_COLUMN_GAP = 10'd2;
  localparam logic [BW_W-1:0]    RST_BYTES_NS   = 11'd32;
  localparam logic [CB_W-1:0]    RST_COL_BYTES  = 13'd32;
  localparam logic [SHIFT_W-1:0] RST_ROW_SHIFT  = 6'd14;
  localparam logic [TIME_W-1:0]  RST_OVERHEAD   = 10'd0;

  typedef struct packed {
    logic              cmd;
    logic [ADDR_W-1:0] address;
    logic [SIZE_W-1:0] size_bytes;
  } in_item_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [LAT_W-1:0]    service_latency;
    logic [ADDR_W-1:0]   started_address;
    logic                row_hit;
    logic [QCNT_W-1:0]   queue_count;
  } out_item_t;

  // Waiting request held in the request queue
  typedef struct packed {
    logic [ADDR_W-1:0] address;
    logic [SIZE_W-1:0] size_bytes;
  } qent_t;

  // Classified transaction passed from front to back
  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic                start;
    logic [ADDR_W-1:0]   address;
    logic [SIZE_W-1:0]   size_bytes;
    logic [QCNT_W-1:0]   queue_count;
  } job_t;

  typedef struct packed {
    logic [TIME_W-1:0]  precharge_latency;
    logic [TIME_W-1:0]  activate_latency;
    logic [TIME_W-1:0]  cas_latency;
    logic [TIME_W-1:0]  column_gap_latency;
    logic [BW_W-1:0]    bytes_per_ns;
    logic [CB_W-1:0]    column_bytes;
    logic [SHIFT_W-1:0] row_shift;
    logic [TIME_W-1:0]  extra_overhead;
  } cfg_t;

  typedef enum logic {
    F_IDLE,
    F_FETCH
  } front_state_t;

  typedef enum logic [2:0] {
    B_IDLE,
    B_DIV_BW,
    B_DIV_COL,
    B_MUL,
    B_SUM,
    B_DONE
  } back_state_t;

endpackage

`default_nettype wire

// ===== hdl/dbors_ram.sv =====
// ============================================================================
// dbors_ram: generic single-write, single-read RAM
// One write port and one read port, read data registered.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module dbors_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

// ===== hdl/dbors_jobq.sv =====
// ============================================================================
// dbors_jobq: two-entry transaction queue between front and back
// Lets the front keep classifying while the back computes a latency.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module dbors_jobq
  import dbors_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic push,
  input  wire job_t push_data,
  output logic      full,
  input  wire logic pop,
  output job_t      pop_data,
  output logic      empty
);

  job_t       slot_r [2];
  logic       wr_r;
  logic       rd_r;
  logic [1:0] cnt_r;
  logic [1:0] cnt_nxt;

  // Track occupancy
  always_comb begin
    unique case ({push, pop})
      2'b10:   cnt_nxt = cnt_r + 2'd1;
      2'b01:   cnt_nxt = cnt_r - 2'd1;
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= 1'b0;
      rd_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) begin
        wr_r <= ~wr_r;
      end
      if (pop) begin
        rd_r <= ~rd_r;
      end
      cnt_r <= cnt_nxt;
    end
  end

  // Store pushed transaction
  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_r] <= push_data;
    end
  end

  assign pop_data = slot_r[rd_r];
  assign full     = (cnt_r == 2'd2);
  assign empty    = (cnt_r == 2'd0);

endmodule

`default_nettype wire

// ===== hdl/dbors_front.sv =====
// ============================================================================
// dbors_front: request classifier and waiting-request queue
// Accepts input transactions, tracks the busy flag and the request queue,
// and hands one classified transaction per input to the back section.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module dbors_front
  import dbors_pkg::*;
#(
  parameter int QUEUE_DEPTH = 8
) (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_ready,
  input  wire in_item_t in_data,
  output logic          jq_push,
  output job_t          jq_data,
  input  wire logic     jq_full
);

  localparam int IDX_W  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int FILL_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [FILL_W-1:0] FILL_MAX = FILL_W'(QUEUE_DEPTH);
  localparam logic [IDX_W-1:0]  IDX_LAST = IDX_W'(QUEUE_DEPTH - 1);
  localparam logic [IDX_W:0]    DEPTH_X  = (IDX_W + 1)'(QUEUE_DEPTH);

  front_state_t      st_r;
  front_state_t      st_nxt;
  logic              busy_r;
  logic              busy_nxt;
  logic [IDX_W-1:0]  head_r;
  logic [IDX_W-1:0]  head_nxt;
  logic [FILL_W-1:0] fill_r;
  logic [FILL_W-1:0] fill_nxt;
  logic              in_fire;
  logic [IDX_W:0]    tail_sum;
  logic [IDX_W-1:0]  tail_idx;
  logic              ram_we;
  logic              ram_re;
  qent_t             ram_wdata;
  qent_t             ram_rdata;

  assign in_ready = (st_r == F_IDLE) && !jq_full;
  assign in_fire  = in_valid && in_ready;

  // Slot behind the last waiting request
  assign tail_sum = (IDX_W + 1)'(head_r) + (IDX_W + 1)'(fill_r);
  assign tail_idx = (tail_sum >= DEPTH_X) ? IDX_W'(tail_sum - DEPTH_X) : IDX_W'(tail_sum);

  assign ram_wdata.address    = in_data.address;
  assign ram_wdata.size_bytes = in_data.size_bytes;

  dbors_ram #(
    .WIDTH ($bits(qent_t)),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (tail_idx),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (head_r),
    .rdata (ram_rdata)
  );

  // Next state: a finish with requests waiting fetches the oldest one
  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      F_IDLE: begin
        if (in_fire && (in_data.cmd == CMD_FINISH) && (fill_r != '0)) begin
          st_nxt = F_FETCH;
        end
      end
      F_FETCH: st_nxt = F_IDLE;
      default: st_nxt = F_IDLE;
    endcase
  end

  // Classify the transaction and update bank and queue bookkeeping
  always_comb begin
    busy_nxt            = busy_r;
    head_nxt            = head_r;
    fill_nxt            = fill_r;
    ram_we              = 1'b0;
    ram_re              = 1'b0;
    jq_push             = 1'b0;
    jq_data             = '0;
    jq_data.queue_count = QCNT_W'(fill_r);
    unique case (st_r)
      F_IDLE: begin
        if (in_fire) begin
          jq_push = 1'b1;
          if (in_data.cmd == CMD_REQUEST) begin
            if (!busy_r) begin
              busy_nxt           = 1'b1;
              jq_data.status     = STS_STARTED;
              jq_data.start      = 1'b1;
              jq_data.address    = in_data.address;
              jq_data.size_bytes = in_data.size_bytes;
            end else if (fill_r != FILL_MAX) begin
              ram_we              = 1'b1;
              fill_nxt            = fill_r + 1'b1;
              jq_data.status      = STS_QUEUED;
              jq_data.queue_count = QCNT_W'(fill_nxt);
            end else begin
              jq_data.status = STS_REJECTED;
            end
          end else begin
            busy_nxt = 1'b0;
            if (fill_r != '0) begin
              // Hold the transaction until the queue entry is read out
              jq_push  = 1'b0;
              ram_re   = 1'b1;
              busy_nxt = 1'b1;
              head_nxt = (head_r == IDX_LAST) ? '0 : head_r + 1'b1;
              fill_nxt = fill_r - 1'b1;
            end else begin
              jq_data.status = STS_FIN_IDLE;
            end
          end
        end
      end
      F_FETCH: begin
        jq_push            = 1'b1;
        jq_data.status     = STS_FIN_NEXT;
        jq_data.start      = 1'b1;
        jq_data.address    = ram_rdata.address;
        jq_data.size_bytes = ram_rdata.size_bytes;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= F_IDLE;
      busy_r <= 1'b0;
      head_r <= '0;
      fill_r <= '0;
    end else begin
      st_r   <= st_nxt;
      busy_r <= busy_nxt;
      head_r <= head_nxt;
      fill_r <= fill_nxt;
    end
  end

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= FILL_MAX)
    else $error("request queue fill above depth");

  a_wait_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (fill_r != '0) |-> busy_r)
    else $error("requests waiting while bank idle");

  a_fetch_cause: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == F_FETCH) |-> ($past(in_fire) && busy_r))
    else $error("queue fetch without accepted finish");

endmodule

`default_nettype wire

// ===== hdl/dbors_back.sv =====
// ============================================================================
// dbors_back: service latency engine
// Resolves row hit and open row, divides the size by bandwidth and column
// size on a shared radix-4 divider, adds the timing terms and registers the
// result transaction.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module dbors_back
  import dbors_pkg::*;
#(
  parameter int ROW_BITS = 15
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire cfg_t cfg,
  input  wire logic jq_empty,
  output logic      jq_pop,
  input  wire job_t jq_data,
  output logic      out_valid,
  input  wire logic out_ready,
  output out_item_t out_data
);

  back_state_t        st_r;
  back_state_t        st_nxt;
  job_t               job_r;
  logic [ROW_BITS-1:0] open_row_r;
  logic               open_valid_r;
  logic               hit_r;
  logic [LAT_W-1:0]   lat_r;
  logic [SIZE_W-1:0]  quo_r;
  logic [CB_W-1:0]    rem_r;
  logic [DIV_CNT_W-1:0] cnt_r;
  logic [SIZE_W-1:0]  extra_r;
  logic [PROD_W-1:0]  prod_r;
  logic               out_valid_r;
  out_item_t          out_data_r;

  logic [ROW_BITS-1:0] row_now;
  logic               hit_now;
  logic [LAT_W-1:0]   base_lat;
  logic [CB_W-1:0]    div_raw;
  logic [CB_W-1:0]    div_d;
  logic [CB_W:0]      s1;
  logic [CB_W:0]      r1;
  logic               q1;
  logic [CB_W:0]      s2;
  logic [CB_W:0]      r2;
  logic               q2;
  logic [SIZE_W-1:0]  quo_step;
  logic [CB_W-1:0]    rem_step;
  logic               out_load;
  out_item_t          out_item;

  // Row lookup for the transaction at the queue head
  assign row_now = ROW_BITS'(jq_data.address >> cfg.row_shift);
  assign hit_now = open_valid_r && (row_now == open_row_r);

  // Fixed latency terms
  always_comb begin
    base_lat = LAT_W'(cfg.cas_latency) + LAT_W'(cfg.extra_overhead);
    if (!hit_now) begin
      base_lat = base_lat + LAT_W'(cfg.activate_latency);
      if (open_valid_r) begin
        base_lat = base_lat + LAT_W'(cfg.precharge_latency);
      end
    end
  end

  // Divider: select divisor, treat zero as one, retire two bits a cycle
  assign div_raw = (st_r == B_DIV_BW) ? CB_W'(cfg.bytes_per_ns) : cfg.column_bytes;
  assign div_d   = (div_raw == '0) ? CB_W'(1) : div_raw;

  always_comb begin
    s1       = {rem_r, quo_r[SIZE_W-1]};
    q1       = (s1 >= {1'b0, div_d});
    r1       = q1 ? (s1 - {1'b0, div_d}) : s1;
    s2       = {r1[CB_W-1:0], quo_r[SIZE_W-2]};
    q2       = (s2 >= {1'b0, div_d});
    r2       = q2 ? (s2 - {1'b0, div_d}) : s2;
    quo_step = {quo_r[SIZE_W-3:0], q1, q2};
    rem_step = r2[CB_W-1:0];
  end

  // Next state
  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      B_IDLE: begin
        if (!jq_empty) begin
          st_nxt = jq_data.start ? B_DIV_BW : B_DONE;
        end
      end
      B_DIV_BW: begin
        if (cnt_r == DIV_LAST) begin
          st_nxt = B_DIV_COL;
        end
      end
      B_DIV_COL: begin
        if (cnt_r == DIV_LAST) begin
          st_nxt = B_MUL;
        end
      end
      B_MUL: st_nxt = B_SUM;
      B_SUM: st_nxt = B_DONE;
      B_DONE: begin
        if (!out_valid_r || out_ready) begin
          st_nxt = B_IDLE;
        end
      end
      default: st_nxt = B_IDLE;
    endcase
  end

  // Outputs: queue pop and result load
  always_comb begin
    jq_pop                   = (st_r == B_IDLE) && !jq_empty;
    out_load                 = (st_r == B_DONE) && (!out_valid_r || out_ready);
    out_item.status          = job_r.status;
    out_item.service_latency = job_r.start ? lat_r : '0;
    out_item.started_address = job_r.address;
    out_item.row_hit         = job_r.start && hit_r;
    out_item.queue_count     = job_r.queue_count;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= B_IDLE;
    end else begin
      st_r <= st_nxt;
    end
  end

  // Open row follows every started request, in order
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      open_valid_r <= 1'b0;
      open_row_r   <= '0;
    end else if (jq_pop && jq_data.start && !hit_now) begin
      open_valid_r <= 1'b1;
      open_row_r   <= row_now;
    end
  end

  // Latency datapath
  always_ff @(posedge clk) begin
    unique case (st_r)
      B_IDLE: begin
        if (jq_pop) begin
          job_r <= jq_data;
          hit_r <= hit_now;
          lat_r <= base_lat;
          quo_r <= jq_data.size_bytes;
          rem_r <= '0;
          cnt_r <= '0;
        end
      end
      B_DIV_BW: begin
        if (cnt_r == DIV_LAST) begin
          lat_r <= lat_r + LAT_W'(quo_step);
          quo_r <= job_r.size_bytes;
          rem_r <= '0;
          cnt_r <= '0;
        end else begin
          quo_r <= quo_step;
          rem_r <= rem_step;
          cnt_r <= cnt_r + 1'b1;
        end
      end
      B_DIV_COL: begin
        if (cnt_r == DIV_LAST) begin
          // Column accesses beyond the first, none below two
          extra_r <= (quo_step < SIZE_W'(2)) ? '0 : quo_step - 1'b1;
        end else begin
          quo_r <= quo_step;
          rem_r <= rem_step;
          cnt_r <= cnt_r + 1'b1;
        end
      end
      B_MUL: prod_r <= PROD_W'(extra_r) * PROD_W'(cfg.column_gap_latency);
      B_SUM: lat_r <= lat_r + LAT_W'(prod_r);
      B_DONE: ;
      default: ;
    endcase
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data_r <= out_item;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_calc_start: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == B_DIV_BW || st_r == B_DIV_COL || st_r == B_MUL || st_r == B_SUM)
      |-> job_r.start)
    else $error("latency computed for a transaction that starts nothing");

  a_hit_status: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r.row_hit)
      |-> (out_data_r.status == STS_STARTED || out_data_r.status == STS_FIN_NEXT))
    else $error("row hit reported without a start");

  a_row_open: assert property (@(posedge clk) disable iff (!rst_n)
    (out_load && job_r.start) |-> open_valid_r)
    else $error("started request left no open row");

endmodule

`default_nettype wire

// ===== hdl/dram_bank_open_row_scheduler_top.sv =====
// ============================================================================
// dram_bank_open_row_scheduler_top: one DRAM bank under an open-row policy
//
// Input channel (in_valid/in_ready/in_data): each transaction is a new
// request (address, size) or a finish notice for the request in service.
// Result channel (out_valid/out_ready/out_data): exactly one result per
// input transaction, in input order: status, service latency, started
// address, row hit and queue count.
// Configuration channel (cfg_valid/cfg_ready/cfg_index/cfg_data): writes the
// eight timing and geometry registers; always ready, write only while idle.
// Steps for a transaction that starts a request: queue pop, two radix-4
// divisions on the shared divider, one multiply, one add, one load; one
// that starts nothing goes from queue pop straight to the load. A finish
// that dequeues a request also waits for the queue RAM read. Throughput is
// set by the back section, which finishes one transaction before it pops
// the next; the two-entry transaction queue lets the front accept ahead of it.
// Reset: bank idle, no row open, queue empty, registers at defaults.
// A stalled receiver holds the result register; the front keeps accepting
// until the transaction queue fills, then drops in_ready.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module dram_bank_open_row_scheduler_top
  import dbors_pkg::*;
#(
  parameter int QUEUE_DEPTH = 8,
  parameter int ROW_BITS    = 15
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire in_item_t              in_data,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output out_item_t                  out_data,
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  cfg_t cfg_r;
  logic jq_push;
  job_t jq_push_data;
  logic jq_full;
  logic jq_pop;
  job_t jq_pop_data;
  logic jq_empty;

  assign cfg_ready = 1'b1;

  // Register file: truncate write data to each register's width
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.precharge_latency  <= RST_PRECHARGE;
      cfg_r.activate_latency   <= RST_ACTIVATE;
      cfg_r.cas_latency        <= RST_CAS;
      cfg_r.column_gap_latency <= RST_COLUMN_GAP;
      cfg_r.bytes_per_ns       <= RST_BYTES_NS;
      cfg_r.column_bytes       <= RST_COL_BYTES;
      cfg_r.row_shift          <= RST_ROW_SHIFT;
      cfg_r.extra_overhead     <= RST_OVERHEAD;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_PRECHARGE:  cfg_r.precharge_latency  <= cfg_data[TIME_W-1:0];
        REG_ACTIVATE:   cfg_r.activate_latency   <= cfg_data[TIME_W-1:0];
        REG_CAS:        cfg_r.cas_latency        <= cfg_data[TIME_W-1:0];
        REG_COLUMN_GAP: cfg_r.column_gap_latency <= cfg_data[TIME_W-1:0];
        REG_BYTES_NS:   cfg_r.bytes_per_ns       <= cfg_data[BW_W-1:0];
        REG_COL_BYTES:  cfg_r.column_bytes       <= cfg_data[CB_W-1:0];
        REG_ROW_SHIFT:  cfg_r.row_shift          <= cfg_data[SHIFT_W-1:0];
        REG_OVERHEAD:   cfg_r.extra_overhead     <= cfg_data[TIME_W-1:0];
        default: ;
      endcase
    end
  end

  dbors_front #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .jq_push  (jq_push),
    .jq_data  (jq_push_data),
    .jq_full  (jq_full)
  );

  dbors_jobq u_jobq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (jq_push),
    .push_data (jq_push_data),
    .full      (jq_full),
    .pop       (jq_pop),
    .pop_data  (jq_pop_data),
    .empty     (jq_empty)
  );

  dbors_back #(
    .ROW_BITS (ROW_BITS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .jq_empty  (jq_empty),
    .jq_pop    (jq_pop),
    .jq_data   (jq_pop_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

// ===== tb/sv/tb_top.sv =====
// ============================================================================
// tb_top: regression bench for the DRAM bank open-row scheduler
// Drives request and finish transactions through the valid/ready input
// channel, predicts each result with a cycle-free model of the bank (busy
// flag, open row, eight-entry wait queue, latency sum) and checks every
// result field in order. Configuration is rewritten between phases while
// the bank is drained, covering zero and full-width register values.
// ============================================================================
`timescale 1ns / 1ps

module tb_top
  import dbors_pkg::*;
();

  localparam int QDEPTH      = 8;
  localparam int ROW_W       = 15;
  localparam int SETTLE      = 40;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int PHASE_ITEMS = 250;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  in_item_t              in_data = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  out_item_t             out_data;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  dram_bank_open_row_scheduler_top #(
    .QUEUE_DEPTH(QDEPTH),
    .ROW_BITS   (ROW_W)
  ) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  // Toggle the clock every half period
  always #1 clk = ~clk;

  // Bank model state
  cfg_t             bank_cfg;
  logic             bank_busy = 1'b0;
  logic [ROW_W-1:0] open_row = '0;
  logic             open_row_valid = 1'b0;
  logic [ADDR_W-1:0] wait_addr [QDEPTH];
  logic [SIZE_W-1:0] wait_size [QDEPTH];
  int unsigned      wait_head = 0;
  int unsigned      wait_fill = 0;

  in_item_t  bank_cmds_pending [$];
  out_item_t bank_results_due  [$];

  int        fail_count = 0;
  int        cycle_count = 0;
  logic [ADDR_W-1:0] hot_addr = '0;

  // Start service: update the open row and return the latency sum
  function automatic logic [LAT_W-1:0] start_latency(input logic [ADDR_W-1:0] addr,
                                                      input logic [SIZE_W-1:0] size,
                                                      output logic hit);
    longint unsigned bw_div, col_div, cols, lat;
    logic [ADDR_W-1:0] shifted;
    logic [ROW_W-1:0]  row;
    bw_div  = (bank_cfg.bytes_per_ns == 0) ? 1 : bank_cfg.bytes_per_ns;
    col_div = (bank_cfg.column_bytes == 0) ? 1 : bank_cfg.column_bytes;
    shifted = addr >> bank_cfg.row_shift;
    row     = shifted[ROW_W-1:0];
    lat     = size / bw_div;
    bank_busy = 1'b1;
    if (open_row_valid && row == open_row) begin
      hit = 1'b1;
    end else begin
      hit = 1'b0;
      if (open_row_valid) lat += bank_cfg.precharge_latency;
      lat += bank_cfg.activate_latency;
      open_row       = row;
      open_row_valid = 1'b1;
    end
    lat += bank_cfg.cas_latency;
    lat += bank_cfg.extra_overhead;
    cols = size / col_div;
    if (cols >= 2) lat += (cols - 1) * bank_cfg.column_gap_latency;
    return LAT_W'(lat);
  endfunction

  // Advance the bank model by one transaction and return its result
  function automatic out_item_t predict_bank_result(input in_item_t it);
    out_item_t   r;
    int unsigned slot;
    logic        hit;
    r = '0;
    if (it.cmd == CMD_REQUEST) begin
      if (!bank_busy) begin
        r.service_latency = start_latency(it.address, it.size_bytes, hit);
        r.row_hit         = hit;
        r.started_address = it.address;
        r.status          = STS_STARTED;
      end else if (wait_fill < QDEPTH) begin
        slot = (wait_head + wait_fill) % QDEPTH;
        wait_addr[slot] = it.address;
        wait_size[slot] = it.size_bytes;
        wait_fill++;
        r.status = STS_QUEUED;
      end else begin
        r.status = STS_REJECTED;
      end
    end else begin
      bank_busy = 1'b0;
      if (wait_fill > 0) begin
        slot = wait_head;
        r.started_address = wait_addr[slot];
        r.service_latency = start_latency(wait_addr[slot], wait_size[slot], hit);
        r.row_hit         = hit;
        wait_head = (wait_head + 1) % QDEPTH;
        wait_fill--;
        r.status = STS_FIN_NEXT;
      end else begin
        r.status = STS_FIN_IDLE;
      end
    end
    r.queue_count = QCNT_W'(wait_fill);
    return r;
  endfunction

  function automatic void check_field(input string name, input logic [63:0] want,
                                      input logic [63:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, actual %0d", name, want, got);
      fail_count++;
    end
  endfunction

  // Write one register; hold cfg_valid high unless this is the last write
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data, input bit last);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      REG_PRECHARGE:  bank_cfg.precharge_latency  = data[TIME_W-1:0];
      REG_ACTIVATE:   bank_cfg.activate_latency   = data[TIME_W-1:0];
      REG_CAS:        bank_cfg.cas_latency        = data[TIME_W-1:0];
      REG_COLUMN_GAP: bank_cfg.column_gap_latency = data[TIME_W-1:0];
      REG_BYTES_NS:   bank_cfg.bytes_per_ns       = data[BW_W-1:0];
      REG_COL_BYTES:  bank_cfg.column_bytes       = data[CB_W-1:0];
      REG_ROW_SHIFT:  bank_cfg.row_shift          = data[SHIFT_W-1:0];
      REG_OVERHEAD:   bank_cfg.extra_overhead     = data[TIME_W-1:0];
      default: ;
    endcase
    if (last) cfg_valid <= 1'b0;
  endtask

  // Write all eight registers, with random bits above each narrower register's width
  task automatic apply_config(input cfg_t c);
    logic [CFG_DATA_W-1:0] junk;
    @(posedge clk);
    junk = CFG_DATA_W'($urandom);
    write_reg(REG_PRECHARGE, {junk[12:10], c.precharge_latency}, 1'b0);
    junk = CFG_DATA_W'($urandom);
    write_reg(REG_ACTIVATE, {junk[12:10], c.activate_latency}, 1'b0);
    junk = CFG_DATA_W'($urandom);
    write_reg(REG_CAS, {junk[12:10], c.cas_latency}, 1'b0);
    junk = CFG_DATA_W'($urandom);
    write_reg(REG_COLUMN_GAP, {junk[12:10], c.column_gap_latency}, 1'b0);
    junk = CFG_DATA_W'($urandom);
    write_reg(REG_BYTES_NS, {junk[12:11], c.bytes_per_ns}, 1'b0);
    write_reg(REG_COL_BYTES, c.column_bytes, 1'b0);
    junk = CFG_DATA_W'($urandom);
    write_reg(REG_ROW_SHIFT, {junk[12:6], c.row_shift}, 1'b0);
    junk = CFG_DATA_W'($urandom);
    write_reg(REG_OVERHEAD, {junk[12:10], c.extra_overhead}, 1'b1);
  endtask

  function automatic in_item_t make_item(input logic cmd, input logic [ADDR_W-1:0] addr,
                                         input logic [SIZE_W-1:0] size);
    in_item_t it;
    it.cmd        = cmd;
    it.address    = addr;
    it.size_bytes = size;
    return it;
  endfunction

  // Random transaction: addresses cluster around a hot row to get hits
  function automatic in_item_t rand_item(input int req_pct);
    logic [ADDR_W-1:0] addr, low_mask, noise;
    logic [SIZE_W-1:0] size;
    logic              cmd;
    int                pick;
    cmd   = ($urandom_range(99) < req_pct) ? CMD_REQUEST : CMD_FINISH;
    noise = {$urandom, $urandom};
    low_mask = (64'd1 << bank_cfg.row_shift) - 64'd1;
    if ($urandom_range(9) == 0) hot_addr = noise;
    pick = $urandom_range(9);
    if (pick < 4)      addr = noise;
    else if (pick < 8) addr = (hot_addr & ~low_mask) | (noise & low_mask);
    else if (pick == 8) addr = hot_addr;
    else               addr = $urandom_range(1) ? '1 : '0;
    pick = $urandom_range(9);
    if (pick == 0)      size = '0;
    else if (pick == 1) size = '1;
    else if (pick < 6)  size = SIZE_W'($urandom_range(256));
    else                size = SIZE_W'($urandom);
    return make_item(cmd, addr, size);
  endfunction

  function automatic cfg_t rand_cfg();
    cfg_t c;
    c.precharge_latency  = TIME_W'($urandom_range(1023));
    c.activate_latency   = TIME_W'($urandom_range(1023));
    c.cas_latency        = TIME_W'($urandom_range(1023));
    c.column_gap_latency = TIME_W'($urandom_range(1023));
    c.bytes_per_ns       = BW_W'($urandom_range(1, 1024));
    c.column_bytes       = CB_W'($urandom_range(1, 4096));
    c.row_shift          = SHIFT_W'($urandom_range(63));
    c.extra_overhead     = TIME_W'($urandom_range(1023));
    return c;
  endfunction

  // Hold until every transaction has been sent and every result has come;
  // sample on the falling edge so the driver's updates have settled
  task automatic wait_drained();
    @(negedge clk);
    while (bank_cmds_pending.size() != 0 || in_valid || bank_results_due.size() != 0)
      @(negedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic run_random_phase(input cfg_t c, input int n_items);
    int req_pct;
    apply_config(c);
    req_pct = 50;
    for (int i = 0; i < n_items; i++) begin
      // switch between filling, balanced and draining regimes
      if (i % 40 == 0) begin
        case ($urandom_range(2))
          0:       req_pct = 80;
          1:       req_pct = 50;
          default: req_pct = 25;
        endcase
      end
      bank_cmds_pending.push_back(rand_item(req_pct));
    end
    wait_drained();
  endtask

  // Driver: send pending transactions in bursts with random gaps
  int burst_left = 0;
  int gap_left = 0;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        bank_results_due.push_back(predict_bank_result(in_data));
      end
      if (in_valid && !in_ready) begin
        // hold the offered transaction
      end else if (gap_left > 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (bank_cmds_pending.size() != 0) begin
        in_data  <= bank_cmds_pending.pop_front();
        in_valid <= 1'b1;
        if (burst_left > 0) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(1, 24);
          case ($urandom_range(9))
            0, 1, 2, 3:    gap_left = 0;
            4, 5, 6, 7:    gap_left = $urandom_range(1, 6);
            default:       gap_left = $urandom_range(10, 40);
          endcase
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Monitor: check each result and stall the result channel on its own pattern
  out_item_t want;
  int        results_seen = 0;
  int        hold_left = 0;
  int        stall_mode = 0;
  int        mode_left = 0;

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (bank_results_due.size() == 0) begin
        $error("result with no transaction outstanding: status %0d", out_data.status);
        fail_count++;
      end else begin
        want = bank_results_due.pop_front();
        check_field("status", want.status, out_data.status);
        check_field("service_latency", want.service_latency, out_data.service_latency);
        check_field("started_address", want.started_address, out_data.started_address);
        check_field("row_hit", want.row_hit, out_data.row_hit);
        check_field("queue_count", want.queue_count, out_data.queue_count);
      end
      results_seen++;
      // long hold-off so the block backs up and drops in_ready
      if (results_seen == 300 || results_seen == 1100) hold_left = 400;
    end
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      if (mode_left == 0) begin
        stall_mode = $urandom_range(2);
        mode_left  = $urandom_range(20, 200);
      end else begin
        mode_left--;
      end
      case (stall_mode)
        0:       out_ready <= 1'b1;
        1:       out_ready <= 1'($urandom_range(1));
        default: out_ready <= ($urandom_range(3) == 0);
      endcase
    end
  end

  // Abort a hung run
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("dram_bank_open_row_scheduler_top regression: fail");
      $finish;
    end
  end

  // Stimulus sequence
  cfg_t phase_cfg;

  initial begin
    bank_cfg.precharge_latency  = RST_PRECHARGE;
    bank_cfg.activate_latency   = RST_ACTIVATE;
    bank_cfg.cas_latency        = RST_CAS;
    bank_cfg.column_gap_latency = RST_COLUMN_GAP;
    bank_cfg.bytes_per_ns       = RST_BYTES_NS;
    bank_cfg.column_bytes       = RST_COL_BYTES;
    bank_cfg.row_shift          = RST_ROW_SHIFT;
    bank_cfg.extra_overhead     = RST_OVERHEAD;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    repeat (4) @(posedge clk);

    // Directed, reset configuration: finish on an idle bank first
    bank_cmds_pending.push_back(make_item(CMD_FINISH, {$urandom, $urandom}, 16'hFFFF));
    // start with no row open, then fill the wait queue with extremes
    bank_cmds_pending.push_back(make_item(CMD_REQUEST, 64'h0, 16'h0));
    bank_cmds_pending.push_back(make_item(CMD_REQUEST, '1, 16'hFFFF));
    bank_cmds_pending.push_back(make_item(CMD_REQUEST, 64'h3FFF, 16'hFFFF));
    bank_cmds_pending.push_back(make_item(CMD_REQUEST, 64'h100, 16'd32));
    bank_cmds_pending.push_back(make_item(CMD_REQUEST, 64'h8000_0000_0000_0000, 16'd1));
    bank_cmds_pending.push_back(make_item(CMD_REQUEST, 64'h4000, 16'd64));
    bank_cmds_pending.push_back(make_item(CMD_REQUEST, 64'h4001, 16'd33));
    bank_cmds_pending.push_back(make_item(CMD_REQUEST, 64'h5555_5555_5555_5555, 16'h5555));
    bank_cmds_pending.push_back(make_item(CMD_REQUEST, 64'hAAAA_AAAA_AAAA_AAAA, 16'hAAAA));
    // queue full: both are rejected
    bank_cmds_pending.push_back(make_item(CMD_REQUEST, 64'h1234, 16'd100));
    bank_cmds_pending.push_back(make_item(CMD_REQUEST, {$urandom, $urandom}, 16'd7));
    // drain: eight dequeues with hits and misses, then an idle finish
    repeat (9) bank_cmds_pending.push_back(make_item(CMD_FINISH, '0, '0));
    // idle start that misses the row left open
    bank_cmds_pending.push_back(make_item(CMD_REQUEST, 64'hAAAA_AAAA_AAAA_0000, 16'd128));
    bank_cmds_pending.push_back(make_item(CMD_FINISH, '1, '1));
    wait_drained();

    // Zero registers: both divisors act as one
    phase_cfg = '0;
    run_random_phase(phase_cfg, PHASE_ITEMS);

    // Full-width registers, beyond the nominal ranges
    phase_cfg = '1;
    run_random_phase(phase_cfg, PHASE_ITEMS);

    repeat (4) run_random_phase(rand_cfg(), PHASE_ITEMS);

    if (fail_count == 0) begin
      $display("dram_bank_open_row_scheduler_top regression: pass");
    end else begin
      $display("dram_bank_open_row_scheduler_top regression: fail");
    end
    $finish;
  end

endmodule
